// ===== src/uyvy2bgr_pkg.sv =====
package uyvy2bgr_pkg;

    localparam int BYTE_W = 8;
    localparam int CHROMA_W = 9;
    localparam int PROD_W = 25;
    localparam int FRAC_BITS = 14;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W = TERM_W + 1;

    localparam int IN_DATA_W = 4 * BYTE_W;
    localparam int OUT_DATA_W = 6 * BYTE_W;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic signed [CHROMA_W-1:0] t_chroma;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_chroma CHROMA_OFFSET = 9'sd128;
    localparam t_prod K_BLUE_U = 25'sd33292;
    localparam t_prod K_GREEN_V = -25'sd9519;
    localparam t_prod K_GREEN_U = 25'sd6472;
    localparam t_prod K_RED_V = 25'sd18678;
    localparam t_prod ROUND_HALF = 25'sd8192;

    localparam t_sum CHAN_MAX = 12'sd255;
    localparam t_byte BYTE_MAX = 8'd255;
    localparam t_byte BYTE_MIN = 8'd0;

    typedef struct packed {
        t_term blue;
        t_term green;
        t_term red;
    } t_terms;

    typedef struct packed {
        t_byte blue;
        t_byte green;
        t_byte red;
    } t_pixel;

endpackage

// ===== src/uyvy2bgr_chroma.sv =====
module uyvy2bgr_chroma (
    input  uyvy2bgr_pkg::t_byte  i_chroma_u,
    input  uyvy2bgr_pkg::t_byte  i_chroma_v,
    output uyvy2bgr_pkg::t_terms o_terms
);
    import uyvy2bgr_pkg::*;

    t_chroma u_c;
    t_chroma v_c;
    t_prod   p_blue;
    t_prod   p_green;
    t_prod   p_red;

    assign u_c = t_chroma'({1'b0, i_chroma_u}) - CHROMA_OFFSET;
    assign v_c = t_chroma'({1'b0, i_chroma_v}) - CHROMA_OFFSET;

    assign p_blue  = t_prod'(u_c) * K_BLUE_U + ROUND_HALF;
    assign p_green = t_prod'(v_c) * K_GREEN_V - t_prod'(u_c) * K_GREEN_U + ROUND_HALF;
    assign p_red   = t_prod'(v_c) * K_RED_V + ROUND_HALF;

    // Taking the upper bits of a two's complement value floors the division.
    assign o_terms.blue  = p_blue[PROD_W-1:FRAC_BITS];
    assign o_terms.green = p_green[PROD_W-1:FRAC_BITS];
    assign o_terms.red   = p_red[PROD_W-1:FRAC_BITS];

endmodule

// ===== src/uyvy2bgr_pixel.sv =====
module uyvy2bgr_pixel (
    input  uyvy2bgr_pkg::t_byte  i_luma,
    input  uyvy2bgr_pkg::t_terms i_terms,
    output uyvy2bgr_pkg::t_pixel o_pixel
);
    import uyvy2bgr_pkg::*;

    t_sum sum_blue;
    t_sum sum_green;
    t_sum sum_red;

    function automatic t_byte clamp(input t_sum value);
        t_byte result;
        if (value < 0) begin
            result = BYTE_MIN;
        end else if (value > CHAN_MAX) begin
            result = BYTE_MAX;
        end else begin
            result = value[BYTE_W-1:0];
        end
        return result;
    endfunction

    assign sum_blue  = t_sum'({1'b0, i_luma}) + t_sum'(i_terms.blue);
    assign sum_green = t_sum'({1'b0, i_luma}) + t_sum'(i_terms.green);
    assign sum_red   = t_sum'({1'b0, i_luma}) + t_sum'(i_terms.red);

    assign o_pixel.blue  = clamp(sum_blue);
    assign o_pixel.green = clamp(sum_green);
    assign o_pixel.red   = clamp(sum_red);

endmodule

// ===== src/uyvy_to_bgr_fixed_point_top.sv =====
// Converts a stream of packed 4:2:2 groups into pairs of BGR pixels.
// Each slave-side transfer carries one group (U, Y1, V, Y2); each master-side
// transfer carries the two pixels of that group, which share its chroma.
// Every group produces exactly one output transfer.
// The block is a two-register pipeline: an input register, the conversion
// logic (four constant multipliers, rounding, add and clamp), and an output
// register. An accepted group waits in the input register until the output
// register is empty or being read; then its result moves into the output
// register, which drives the master side. A receiver stall can hold it back.
// Throughput is one group per cycle when the receiver does not stall; the
// chroma multipliers and their adders, between the registers, set the clock period.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more group; only when both are full does
// o_s_tready go low.
// Synchronous reset empties both registers; no result is pending after it.
module uyvy_to_bgr_fixed_point_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields from bit 0: chroma_u, luma_first, chroma_v, luma_second.
    input  logic [uyvy2bgr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0: blue_first, green_first, red_first,
    // blue_second, green_second, red_second.
    output logic [uyvy2bgr_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import uyvy2bgr_pkg::*;

    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  advance;
    logic                  s_accept;
    t_terms                terms;
    t_pixel                pixel_first;
    t_pixel                pixel_second;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    uyvy2bgr_chroma u_chroma (
        .i_chroma_u (r_in_data[BYTE_W-1:0]),
        .i_chroma_v (r_in_data[3*BYTE_W-1:2*BYTE_W]),
        .o_terms    (terms)
    );

    uyvy2bgr_pixel u_pixel_first (
        .i_luma  (r_in_data[2*BYTE_W-1:BYTE_W]),
        .i_terms (terms),
        .o_pixel (pixel_first)
    );

    uyvy2bgr_pixel u_pixel_second (
        .i_luma  (r_in_data[4*BYTE_W-1:3*BYTE_W]),
        .i_terms (terms),
        .o_pixel (pixel_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data <= i_s_tdata;
        end
        if (advance && r_in_valid) begin
            r_out_data <= {pixel_second.red, pixel_second.green, pixel_second.blue,
                           pixel_first.red, pixel_first.green, pixel_first.blue};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== src/uyvy2bgr_checker.sv =====
module uyvy2bgr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [uyvy2bgr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [uyvy2bgr_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled output transfer changed or dropped.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid after reset.");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("Input refused while the output was not stalled.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready ##1 i_m_tready |=> o_m_tvalid)
        else $error("Accepted group did not reach the output in two cycles.");

endmodule

bind uyvy_to_bgr_fixed_point_top uyvy2bgr_checker u_checker (.*);

// ===== sim/uyvy_to_bgr_fixed_point_checker.sv =====
`timescale 1ns / 1ps

module uyvy_to_bgr_fixed_point_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // Fields from bit 0: chroma_u, luma_first, chroma_v, luma_second.
    input  logic [uyvy2bgr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0: blue_first, green_first, red_first,
    // blue_second, green_second, red_second.
    input  logic [uyvy2bgr_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import uyvy2bgr_pkg::*;

    localparam int OFFSET = 128;
    localparam int HALF = 8192;
    localparam int SHIFT = 14;
    localparam int GAIN_BLUE_U = 33292;
    localparam int GAIN_GREEN_V = -9519;
    localparam int GAIN_GREEN_U = 6472;
    localparam int GAIN_RED_V = 18678;
    localparam int MAX_PRINTED = 40;

    logic [OUT_DATA_W-1:0] expected_pixel_pairs[$];
    int                    error_count;
    string                 channel_names[6] = '{"blue_first", "green_first", "red_first",
                                                "blue_second", "green_second", "red_second"};

    assign o_fail_count = error_count;

    function automatic t_byte saturate_byte(input int value);
        if (value < 0) begin
            return 8'd0;
        end
        if (value > 255) begin
            return 8'd255;
        end
        return value[7:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] convert_group(input logic [IN_DATA_W-1:0] group);
        int                    u;
        int                    v;
        int                    luma[2];
        int                    blue_term;
        int                    green_term;
        int                    red_term;
        logic [OUT_DATA_W-1:0] pair;
        u = group[7:0];
        luma[0] = group[15:8];
        v = group[23:16];
        luma[1] = group[31:24];
        u = u - OFFSET;
        v = v - OFFSET;
        // Arithmetic shifts of negative sums round toward minus infinity.
        blue_term = (u * GAIN_BLUE_U + HALF) >>> SHIFT;
        green_term = (v * GAIN_GREEN_V - u * GAIN_GREEN_U + HALF) >>> SHIFT;
        red_term = (v * GAIN_RED_V + HALF) >>> SHIFT;
        for (int i = 0; i < 2; i++) begin
            pair[i*24 +: 8] = saturate_byte(luma[i] + blue_term);
            pair[i*24+8 +: 8] = saturate_byte(luma[i] + green_term);
            pair[i*24+16 +: 8] = saturate_byte(luma[i] + red_term);
        end
        return pair;
    endfunction

    task automatic report_mismatch(input string what, input int expected_value,
                                   input int actual_value);
        if (error_count < MAX_PRINTED) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what,
                     expected_value, actual_value);
        end
        error_count++;
    endtask

    initial begin
        error_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] expected_pair;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_pixel_pairs.insert(expected_pixel_pairs.size(),
                                            convert_group(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixel_pairs.size() == 0) begin
                    report_mismatch("output transfer with nothing pending, data", 0,
                                    int'(i_m_tdata[31:0]));
                end else begin
                    expected_pair = expected_pixel_pairs.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (i_m_tdata[i*8 +: 8] !== expected_pair[i*8 +: 8]) begin
                            report_mismatch(channel_names[i], expected_pair[i*8 +: 8],
                                            i_m_tdata[i*8 +: 8]);
                        end
                    end
                end
            end
            o_pending <= expected_pixel_pairs.size();
        end
    end

endmodule

// ===== sim/uyvy_to_bgr_fixed_point_top_test.sv =====
`timescale 1ns / 1ps

module uyvy_to_bgr_fixed_point_top_test;

    import uyvy2bgr_pkg::*;

    localparam int RANDOM_GROUPS = 1830;
    localparam int PAUSE_AT_GROUP = 900;
    localparam int HOLD_AFTER_RESULTS = 500;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  hold_active;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;

    uyvy_to_bgr_fixed_point_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    uyvy_to_bgr_fixed_point_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #1 clk = ~clk;
        end
    end

    function automatic t_byte pick_byte();
        t_byte corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 99) < 15) begin
            return corners[$urandom_range(0, 6)];
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_group(input t_byte u, input t_byte y1, input t_byte v, input t_byte y2);
        s_tvalid <= 1'b1;
        s_tdata <= {y2, v, y1, u};
        do begin
            @(posedge clk);
        end while (!s_tready);
    endtask

    task automatic idle_cycles(input int count);
        if (count > 0) begin
            s_tvalid <= 1'b0;
            repeat (count) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("uyvy_to_bgr_fixed_point_top: mismatch");
        $finish;
    end

    initial begin
        int results_seen;
        int hold_left;
        int stall_left;
        int segment_left;
        int ready_mode;
        bit hold_done;
        m_tready = 1'b0;
        hold_active = 1'b0;
        results_seen = 0;
        hold_left = 0;
        stall_left = 0;
        segment_left = 0;
        ready_mode = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                results_seen++;
            end
            if (results_seen >= HOLD_AFTER_RESULTS && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_active <= 1'b1;
                m_tready <= 1'b0;
            end else begin
                hold_active <= 1'b0;
                if (segment_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    segment_left = $urandom_range(20, 200);
                end
                segment_left--;
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    case (ready_mode)
                        0: begin
                            m_tready <= 1'b1;
                        end
                        1: begin
                            m_tready <= ($urandom_range(0, 3) != 0);
                        end
                        2: begin
                            m_tready <= ($urandom_range(0, 2) == 0);
                        end
                        default: begin
                            if ($urandom_range(0, 19) == 0) begin
                                stall_left = $urandom_range(10, 30);
                                m_tready <= 1'b0;
                            end else begin
                                m_tready <= 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    initial begin
        int burst_left;
        bit no_gaps;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        burst_left = 0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_group(8'd0, 8'd0, 8'd0, 8'd0);
        send_group(8'd255, 8'd255, 8'd255, 8'd255);
        send_group(8'd128, 8'd0, 8'd128, 8'd255);
        send_group(8'd0, 8'd0, 8'd0, 8'd255);
        send_group(8'd255, 8'd255, 8'd255, 8'd0);
        send_group(8'd0, 8'd128, 8'd255, 8'd64);
        send_group(8'd255, 8'd128, 8'd0, 8'd192);
        send_group(8'h55, 8'h55, 8'h55, 8'h55);
        send_group(8'hAA, 8'hAA, 8'hAA, 8'hAA);
        send_group(8'd255, 8'd200, 8'd128, 8'd30);
        send_group(8'd128, 8'd200, 8'd255, 8'd30);
        send_group(8'd0, 8'd50, 8'd128, 8'd240);
        send_group(8'd128, 8'd50, 8'd0, 8'd240);
        send_group(8'd0, 8'd200, 8'd0, 8'd128);
        send_group(8'd255, 8'd60, 8'd255, 8'd128);
        send_group(8'd129, 8'd100, 8'd127, 8'd1);
        send_group(8'd127, 8'd100, 8'd129, 8'd254);
        send_group(8'd130, 8'd17, 8'd126, 8'd238);
        idle_cycles(3);

        for (int n = 0; n < RANDOM_GROUPS; n++) begin
            if (burst_left == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(16, 96);
            end
            burst_left--;
            send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte());
            if (n == PAUSE_AT_GROUP) begin
                wait_until_drained();
            end else if (!no_gaps && !hold_active) begin
                idle_cycles(pick_gap());
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("uyvy_to_bgr_fixed_point_top: match");
        end else begin
            $display("uyvy_to_bgr_fixed_point_top: mismatch");
        end
        $finish;
    end

endmodule
